@@ hw/rtl/stu_pkg.sv @@
// Package for the string to unsigned parser: widths, phase and status codes,
// parse state and result structs, and the character class helpers.
// No dependencies.
package stu_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;
    localparam int BASE_WIDTH   = 6;
    localparam int CHAR_WIDTH   = 8;
    localparam int STATUS_WIDTH = 2;
    localparam int PROD_WIDTH   = VALUE_WIDTH + BASE_WIDTH;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0]  VALUE_MAX  = {VALUE_WIDTH{1'b1}};

    localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX  = 6'd36;

    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_X,
        PH_DIGITS
    } phase_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_BAD_BASE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        phase_t                  phase;
        logic [VALUE_WIDTH-1:0]  accumulator;
        logic                    negative;
        logic [BASE_WIDTH-1:0]   active_base;
        logic [OFFSET_WIDTH-1:0] position;
        logic [OFFSET_WIDTH-1:0] zero_end;
        logic                    overflowed;
        logic                    digit_seen;
    } parse_state_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        logic [OFFSET_WIDTH-1:0] end_offset;
        status_t                 status;
    } parse_result_t;

    // Returns {is_alnum, digit value}; digit value is 0..35.
    function automatic logic [BASE_WIDTH:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [BASE_WIDTH:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, BASE_WIDTH'(c - CH_ZERO)};
        end else if (c >= CH_UA && c <= CH_UZ) begin
            r = {1'b1, BASE_WIDTH'(c - CH_UA + 8'd10)};
        end else if (c >= CH_LA && c <= CH_LZ) begin
            r = {1'b1, BASE_WIDTH'(c - CH_LA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

@@ hw/rtl/string_to_unsigned_parser_core.sv @@
// Top level of the string to unsigned parser: input register, parse state,
// result register and the base register. Depends on stu_pkg and stu_step.
//
// Feed one character per request; first = 1 starts a new string and latches
// number_base (0 auto-detects the radix, 2..36 fixes it). The block takes one
// character every cycle unless in_stall holds it while the result register is
// full and stalled. A character is held in the input register and is parsed on
// the way into the result register; the cycle time is set by the 64 by 6 bit
// multiply-add with its overflow check on the accumulator.
// One result per string: value, end_offset and status (ok, no digits,
// invalid base, overflow). Write number_base only while no string is in flight.
module string_to_unsigned_parser_core
    import stu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     number_base_we,
    input  logic [BASE_WIDTH-1:0]    number_base,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CHAR_WIDTH-1:0]    char_code,
    input  logic                     first,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [VALUE_WIDTH-1:0]   value,
    output logic [OFFSET_WIDTH-1:0]  end_offset,
    output logic [STATUS_WIDTH-1:0]  status
);

    logic                  in_valid_reg;
    logic [CHAR_WIDTH-1:0] char_reg;
    logic                  first_reg;
    logic [BASE_WIDTH-1:0] base_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    logic                  out_valid_reg;
    parse_result_t         result_reg;
    parse_result_t         result_next;
    logic                  emit;
    logic                  advance;

    stu_step u_step (
        .cur       (state_reg),
        .char_code (char_reg),
        .first     (first_reg),
        .cfg_base  (base_reg),
        .nxt       (state_next),
        .emit      (emit),
        .res       (result_next)
    );

    // The parse stage moves whenever the result register is free or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            base_reg      <= BASE_AUTO;
            state_reg     <= '{phase: PH_IDLE, accumulator: '0, negative: 1'b0,
                               active_base: '0, position: '0, zero_end: '0,
                               overflowed: 1'b0, digit_seen: 1'b0};
            out_valid_reg <= 1'b0;
        end else begin
            if (number_base_we) begin
                base_reg <= number_base;
            end
            if (!in_stall) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg && emit;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            char_reg  <= char_code;
            first_reg <= first;
        end
        if (advance && in_valid_reg && emit) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = result_reg.value;
    assign end_offset = result_reg.end_offset;
    assign status     = result_reg.status;

`ifndef SYNTHESIS
    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result register could drain");

    a_result_from_parse_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared with no character in the parse stage");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.status == ST_OVERFLOW) |-> (result_reg.value == VALUE_MAX))
        else $error("overflow result not saturated");

    a_empty_results_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status == ST_NO_DIGITS ||
                           result_reg.status == ST_BAD_BASE))
        |-> (result_reg.value == '0 && result_reg.end_offset == '0))
        else $error("no-digit or bad-base result carries a value");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg.phase == PH_IDLE))
        else $error("parse still active after its result");
`endif

endmodule

@@ hw/rtl/stu_step.sv @@
// Next-state and result logic for one character of the parser.
// Purely combinational; depends on stu_pkg.
module stu_step
    import stu_pkg::*;
(
    input  parse_state_t            cur,
    input  logic [CHAR_WIDTH-1:0]   char_code,
    input  logic                    first,
    input  logic [BASE_WIDTH-1:0]   cfg_base,
    output parse_state_t            nxt,
    output logic                    emit,
    output parse_result_t           res
);

    logic [OFFSET_WIDTH-1:0] p;
    logic                    go;
    logic                    do_finish;
    logic [OFFSET_WIDTH-1:0] finish_off;
    logic [BASE_WIDTH:0]     dig;
    logic [PROD_WIDTH-1:0]   prod;

    always_comb
    begin
        nxt        = cur;
        emit       = 1'b0;
        res        = '{value: '0, end_offset: '0, status: ST_OK};
        p          = '0;
        go         = 1'b0;
        do_finish  = 1'b0;
        finish_off = '0;
        dig        = digit_of(char_code);
        prod       = '0;

        if (first) begin
            nxt.phase       = PH_LEAD;
            nxt.accumulator = '0;
            nxt.negative    = 1'b0;
            nxt.active_base = cfg_base;
            nxt.position    = '0;
            nxt.zero_end    = '0;
            nxt.overflowed  = 1'b0;
            nxt.digit_seen  = 1'b0;
            if (cfg_base == BASE_ONE || cfg_base > BASE_MAX) begin
                emit       = 1'b1;
                res.status = ST_BAD_BASE;
                nxt.phase  = PH_IDLE;
            end
        end

        if (!emit && nxt.phase != PH_IDLE) begin
            p  = nxt.position;
            go = 1'b1;
            if (nxt.position != OFFSET_MAX) begin
                nxt.position = nxt.position + 1'b1;
            end

            if (nxt.phase == PH_LEAD) begin
                if (is_space(char_code)) begin
                    go = 1'b0;
                end else begin
                    nxt.phase = PH_SIGN;
                    if (char_code == CH_PLUS) begin
                        go = 1'b0;
                    end else if (char_code == CH_MINUS) begin
                        nxt.negative = 1'b1;
                        go           = 1'b0;
                    end
                end
            end

            if (go) begin
                case (nxt.phase)
                    PH_SIGN:
                    begin
                        if (char_code == CH_ZERO &&
                            (nxt.active_base == BASE_AUTO || nxt.active_base == BASE_HEX)) begin
                            nxt.digit_seen = 1'b1;
                            nxt.zero_end   = nxt.position;
                            nxt.phase      = PH_ZERO;
                            go             = 1'b0;
                        end else begin
                            if (nxt.active_base == BASE_AUTO) begin
                                nxt.active_base = BASE_DEC;
                            end
                            nxt.phase = PH_DIGITS;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (char_code == CH_LX || char_code == CH_UX) begin
                            nxt.active_base = BASE_HEX;
                            nxt.phase       = PH_X;
                            go              = 1'b0;
                        end else begin
                            if (nxt.active_base == BASE_AUTO) begin
                                nxt.active_base = BASE_OCT;
                            end
                            nxt.phase = PH_DIGITS;
                        end
                    end
                    PH_X:
                    begin
                        // "0x" with no hex digit: the zero alone is the number
                        if (!dig[BASE_WIDTH] || dig[BASE_WIDTH-1:0] >= BASE_HEX) begin
                            nxt.accumulator = '0;
                            do_finish       = 1'b1;
                            finish_off      = nxt.zero_end;
                            go              = 1'b0;
                        end else begin
                            nxt.phase = PH_DIGITS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (go) begin
                if (!dig[BASE_WIDTH] || dig[BASE_WIDTH-1:0] >= nxt.active_base) begin
                    do_finish  = 1'b1;
                    finish_off = p;
                end else begin
                    nxt.digit_seen = 1'b1;
                    if (!nxt.overflowed) begin
                        // acc * base + d exceeds the value range exactly when it overflows
                        prod = PROD_WIDTH'(nxt.accumulator) * PROD_WIDTH'(nxt.active_base)
                             + PROD_WIDTH'(dig[BASE_WIDTH-1:0]);
                        if (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0) begin
                            nxt.overflowed  = 1'b1;
                            nxt.accumulator = VALUE_MAX;
                        end else begin
                            nxt.accumulator = prod[VALUE_WIDTH-1:0];
                        end
                    end
                end
            end

            if (do_finish) begin
                emit      = 1'b1;
                nxt.phase = PH_IDLE;
                if (!nxt.digit_seen) begin
                    res.status = ST_NO_DIGITS;
                end else if (nxt.overflowed) begin
                    res.value      = VALUE_MAX;
                    res.end_offset = finish_off;
                    res.status     = ST_OVERFLOW;
                end else begin
                    res.value      = nxt.negative ? (VALUE_WIDTH'(0) - nxt.accumulator)
                                                  : nxt.accumulator;
                    res.end_offset = finish_off;
                    res.status     = ST_OK;
                end
            end
        end
    end

endmodule

@@ dv/string_to_unsigned_parser_core_tb.sv @@
// Testbench for string_to_unsigned_parser_core: sends character requests with
// random gaps and output stalls, predicts every parse result and checks it in order.
// Depends on stu_pkg and the parser core RTL.
module string_to_unsigned_parser_core_tb
    import stu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 4;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    number_base_we = 1'b0;
    logic [BASE_WIDTH-1:0]   number_base = BASE_AUTO;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CHAR_WIDTH-1:0]   char_code = '0;
    logic                    first = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [VALUE_WIDTH-1:0]  value;
    logic [OFFSET_WIDTH-1:0] end_offset;
    logic [STATUS_WIDTH-1:0] status;

    // Parser state as predicted, with the base register copy
    phase_t                  prs_phase = PH_IDLE;
    logic [VALUE_WIDTH-1:0]  prs_acc = '0;
    logic                    prs_neg = 1'b0;
    logic [BASE_WIDTH-1:0]   prs_base = '0;
    logic [OFFSET_WIDTH-1:0] prs_pos = '0;
    logic [OFFSET_WIDTH-1:0] prs_zero_end = '0;
    logic                    prs_ovf = 1'b0;
    logic                    prs_seen = 1'b0;
    logic [BASE_WIDTH-1:0]   base_reg = BASE_AUTO;

    parse_result_t           pending_results[$];
    int                      mismatches = 0;
    int                      chars_sent = 0;
    bit                      no_gaps = 1'b0;
    bit                      long_hold = 1'b0;
    bit                      string_start = 1'b1;

    string_to_unsigned_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .number_base_we (number_base_we),
        .number_base    (number_base),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .first          (first),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .end_offset     (end_offset),
        .status         (status)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL string_to_unsigned_parser_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Digit value of an alphanumeric byte, 99 for anything else
    function automatic int char_digit(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ)
            return int'(c) - int'(CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LZ)
            return int'(c) - int'(CH_LA) + 10;
        return 99;
    endfunction

    function automatic void post_result(input logic [VALUE_WIDTH-1:0] v,
                                        input logic [OFFSET_WIDTH-1:0] off,
                                        input status_t st);
        parse_result_t r;
        r.value      = v;
        r.end_offset = off;
        r.status     = st;
        pending_results.push_back(r);
        prs_phase = PH_IDLE;
    endfunction

    function automatic void finish_parse(input logic [OFFSET_WIDTH-1:0] off);
        if (!prs_seen)
            post_result('0, '0, ST_NO_DIGITS);
        else if (prs_ovf)
            post_result(VALUE_MAX, off, ST_OVERFLOW);
        else
            post_result(prs_neg ? -prs_acc : prs_acc, off, ST_OK);
    endfunction

    function automatic void parse_char(input logic [CHAR_WIDTH-1:0] c, input logic f);
        logic [OFFSET_WIDTH-1:0] stop_at;
        logic [PROD_WIDTH-1:0]   prod;
        int                      d;
        if (f)
        begin
            prs_phase    = PH_LEAD;
            prs_acc      = '0;
            prs_neg      = 1'b0;
            prs_base     = base_reg;
            prs_pos      = '0;
            prs_zero_end = '0;
            prs_ovf      = 1'b0;
            prs_seen     = 1'b0;
            if (prs_base == BASE_ONE || prs_base > BASE_MAX)
            begin
                post_result('0, '0, ST_BAD_BASE);
                return;
            end
        end
        if (prs_phase == PH_IDLE)
            return;

        stop_at = prs_pos;
        if (prs_pos != OFFSET_MAX)
            prs_pos = prs_pos + 1'b1;

        if (prs_phase == PH_LEAD)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            prs_phase = PH_SIGN;
            if (c == CH_PLUS)
                return;
            if (c == CH_MINUS)
            begin
                prs_neg = 1'b1;
                return;
            end
        end

        if (prs_phase == PH_SIGN)
        begin
            // a leading zero is a digit in its own right and may open a 0x prefix
            if (c == CH_ZERO && (prs_base == BASE_AUTO || prs_base == BASE_HEX))
            begin
                prs_seen     = 1'b1;
                prs_zero_end = prs_pos;
                prs_phase    = PH_ZERO;
                return;
            end
            if (prs_base == BASE_AUTO)
                prs_base = BASE_DEC;
            prs_phase = PH_DIGITS;
        end
        else if (prs_phase == PH_ZERO)
        begin
            if (c == CH_LX || c == CH_UX)
            begin
                prs_base  = BASE_HEX;
                prs_phase = PH_X;
                return;
            end
            if (prs_base == BASE_AUTO)
                prs_base = BASE_OCT;
            prs_phase = PH_DIGITS;
        end
        else if (prs_phase == PH_X)
        begin
            // 0x with no hex digit after it: the number is the lone zero
            if (char_digit(c) >= 16)
            begin
                prs_acc = '0;
                finish_parse(prs_zero_end);
                return;
            end
            prs_phase = PH_DIGITS;
        end

        d = char_digit(c);
        if (d >= int'(prs_base))
        begin
            finish_parse(stop_at);
            return;
        end
        prs_seen = 1'b1;
        if (!prs_ovf)
        begin
            prod = PROD_WIDTH'(prs_acc) * PROD_WIDTH'(prs_base) + PROD_WIDTH'(d);
            if (prod[PROD_WIDTH-1:VALUE_WIDTH] != '0)
            begin
                prs_ovf = 1'b1;
                prs_acc = VALUE_MAX;
            end
            else
                prs_acc = prod[VALUE_WIDTH-1:0];
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            parse_char(char_code, first);
    end

    always @(posedge clk)
    begin : check_result
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value %h end_offset %0d status %0d",
                       value, end_offset, status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %h, actual %h", want.value, value);
                    mismatches++;
                end
                if (end_offset !== want.end_offset)
                begin
                    $error("end_offset: expected %0d, actual %0d", want.end_offset, end_offset);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall runs, plus one long hold-off on demand
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int roll;
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                out_stall <= (roll < 30);
                if (roll < 24)
                    n = $urandom_range(1, 3);
                else if (roll < 30)
                    n = $urandom_range(10, 40);
                else
                    n = $urandom_range(1, 25);
                repeat (n) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request
    task automatic send_char(input logic [CHAR_WIDTH-1:0] c, input logic f);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        first     <= f;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
    endtask

    task automatic put_char(input logic [CHAR_WIDTH-1:0] c);
        send_char(c, string_start);
        string_start = 1'b0;
    endtask

    task automatic send_str(input string s, input bit terminate);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], i == 0);
        if (terminate)
            send_char(8'h00, s.len() == 0);
    endtask

    // Close any open string, drain results and let the pipe empty
    task automatic settle();
        send_char(8'h00, 1'b0);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_base(input logic [BASE_WIDTH-1:0] b);
        settle();
        number_base_we <= 1'b1;
        number_base    <= b;
        @(posedge clk);
        number_base_we <= 1'b0;
        base_reg = b;
    endtask

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input int v);
        if (v < 10)
            return CH_ZERO + CHAR_WIDTH'(v);
        if ($urandom_range(0, 1) == 0)
            return CH_LA + CHAR_WIDTH'(v - 10);
        return CH_UA + CHAR_WIDTH'(v - 10);
    endfunction

    // Mostly well-formed numbers with random content, the rest noise
    task automatic send_random_string();
        int roll;
        int n;
        int i;
        int radix;
        int ws;
        string_start = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                // the odd restart in the middle of a string
                send_char(8'($urandom_range(0, 255)), string_start || $urandom_range(0, 9) == 0);
                string_start = 1'b0;
            end
            return;
        end

        if (base_reg >= 2 && base_reg <= BASE_MAX)
            radix = int'(base_reg);
        else
            radix = 10;

        if ($urandom_range(0, 9) < 3)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                ws = $urandom_range(8, 13);
                put_char(ws == 8 ? CH_SPACE : CHAR_WIDTH'(ws));
            end
        end

        roll = $urandom_range(0, 99);
        if (roll < 15)
            put_char(CH_PLUS);
        else if (roll < 40)
            put_char(CH_MINUS);

        roll = $urandom_range(0, 99);
        if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && roll < 30)
        begin
            put_char(CH_ZERO);
            put_char($urandom_range(0, 1) ? CH_LX : CH_UX);
            radix = 16;
        end
        else if (base_reg == BASE_AUTO && roll < 50)
        begin
            put_char(CH_ZERO);
            radix = 8;
        end

        roll = $urandom_range(0, 99);
        if (roll < 8)
            n = 0;
        else if (roll < 80)
            n = $urandom_range(1, 8);
        else
            n = $urandom_range(12, 70);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                put_char(digit_char(radix - 1));
            else
                put_char(digit_char($urandom_range(0, radix - 1)));
        end

        roll = $urandom_range(0, 99);
        if (roll < 60)
            put_char(8'h00);
        else if (roll < 85)
            put_char(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs on the reset value of number_base: auto-detect
    task automatic test_auto_detect();
        send_char("7", 1'b0);                   // idle, no string open: dropped
        send_str(" \t\n\v\f\r-123", 1'b1);
        send_str("+0x1F", 1'b1);
        send_str("0Xg", 1'b0);
        send_str("0x", 1'b1);
        send_str("0178", 1'b0);
        send_str("0", 1'b1);
        send_str("+", 1'b1);
        send_str("", 1'b1);
        send_char(8'hFF, 1'b1);
        send_str("18446744073709551615", 1'b1);
        send_str("18446744073709551616", 1'b1);
        send_str("-1", 1'b1);
        send_str("-99999999999999999999", 1'b1);
        send_str("12", 1'b0);
        send_str("34", 1'b1);                   // restart drops the open string
    endtask

    task automatic test_fixed_bases();
        set_base(BASE_MAX);
        send_str("zZ", 1'b1);
        set_base(6'd2);
        send_str("-102", 1'b1);
        set_base(BASE_HEX);
        send_str("0xfF!", 1'b0);
        send_str("ff", 1'b1);
        set_base(BASE_ONE);
        send_str("5", 1'b1);
        set_base(6'd37);
        send_str("5", 1'b1);
        set_base(6'd63);
        send_str("55", 1'b1);
        set_base(BASE_OCT);
        send_str("-777", 1'b1);
        set_base(BASE_DEC);
        send_str("0x5", 1'b1);
        set_base(BASE_AUTO);
        send_str("  42", 1'b1);
    endtask

    // Hold the result side off while requests keep coming, so the core backs up
    task automatic test_stall_pressure();
        int i;
        set_base(BASE_DEC);
        long_hold = 1'b1;
        no_gaps   = 1'b1;
        for (i = 0; i < 40; i++)
        begin
            send_char(digit_char($urandom_range(0, 9)), 1'b1);
            send_char(8'h00, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_strings();
        int total_end;
        int phase_end;
        logic [BASE_WIDTH-1:0] b;
        total_end = chars_sent + 520;
        while (chars_sent < total_end)
        begin
            case ($urandom_range(0, 9))
                0, 1:    b = BASE_AUTO;
                2:       b = BASE_DEC;
                3:       b = BASE_HEX;
                4:       b = BASE_OCT;
                5:       b = 6'd2;
                6:       b = BASE_MAX;
                7:       b = 6'($urandom_range(2, 36));
                8:       b = BASE_ONE;
                default: b = 6'($urandom_range(37, 63));
            endcase
            set_base(b);
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_end = chars_sent + $urandom_range(40, 120);
            while (chars_sent < phase_end)
                send_random_string();
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_auto_detect();
        test_fixed_bases();
        test_stall_pressure();
        test_random_strings();
        settle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS string_to_unsigned_parser_core");
        else
            $display("FAIL string_to_unsigned_parser_core");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/stu_pkg.sv
hw/rtl/stu_step.sv
hw/rtl/string_to_unsigned_parser_core.sv
dv/string_to_unsigned_parser_core_tb.sv
